// ===== sv/tcc_pkg.sv =====
// Shared constants and sizes for the text cell console engine.
package tcc_pkg;

   // Screen store geometry.
   localparam int STORE_COLS  = 128;
   localparam int STORE_ROWS  = 64;
   localparam int COL_W       = $clog2(STORE_COLS);
   localparam int ROW_W       = $clog2(STORE_ROWS);
   localparam int CNTC_W      = $clog2(STORE_COLS + 1);
   localparam int CNTR_W      = $clog2(STORE_ROWS + 1);
   localparam int ADDR_W      = ROW_W + COL_W;
   localparam int STORE_DEPTH = STORE_ROWS * (1 << COL_W);

   // Word field widths.
   localparam int CHAR_W     = 8;
   localparam int FROW_W     = 6;
   localparam int FCOL_W     = 7;

   // Configuration port.
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = CSR_IDX_W'(1);

   // Request kinds.
   localparam logic REQ_PUT  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Control characters.
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

endpackage

// ===== sv/tcc_ifs.sv =====
// Handshake channel interfaces for requests, responses and configuration.
interface tcc_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [tcc_pkg::CHAR_W-1:0]     char_code;
   logic [tcc_pkg::FROW_W-1:0]     read_row;
   logic [tcc_pkg::FCOL_W-1:0]     read_col;

   modport source (output valid, req_type, char_code, read_row, read_col, input ready);
   modport sink   (input valid, req_type, char_code, read_row, read_col, output ready);
endinterface

interface tcc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           cell_written;
   logic [tcc_pkg::FROW_W-1:0]     written_row;
   logic [tcc_pkg::FCOL_W-1:0]     written_col;
   logic [tcc_pkg::CHAR_W-1:0]     written_char;
   logic                           did_scroll;
   logic [tcc_pkg::FROW_W-1:0]     cursor_row_now;
   logic [tcc_pkg::FCOL_W-1:0]     cursor_col_now;
   logic [tcc_pkg::CHAR_W-1:0]     read_char;

   modport source (output valid, cell_written, written_row, written_col, written_char,
                   did_scroll, cursor_row_now, cursor_col_now, read_char, input ready);
   modport sink   (input valid, cell_written, written_row, written_col, written_char,
                   did_scroll, cursor_row_now, cursor_col_now, read_char, output ready);
endinterface

interface tcc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [tcc_pkg::CSR_IDX_W-1:0]     reg_index;
   logic [tcc_pkg::CSR_DATA_W-1:0]    wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== sv/tcc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module tcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/text_cell_console_engine.sv =====
// Character-cell console: cursor handling and scrolling over one cell memory.
// A put word passes through the EXEC and FINISH states before its response is registered;
// a read word also passes RDATA. No new word is taken until then; FINISH waits while
// an earlier response is still held. A put that scrolls copies (rows-1)*cols cells
// through the single write port, then blanks cols cells (only blanks when one row is in use).
// After reset all 8192 cells are swept to zero before requests are taken.
module text_cell_console_engine (
   input  logic         clock,
   input  logic         reset,
   tcc_req_if.sink      req_ch,
   tcc_rsp_if.source    rsp_ch,
   tcc_csr_if.sink      csr_ch
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_RDATA  = 3'd3;
   localparam logic [2:0] ST_COPY   = 3'd4;
   localparam logic [2:0] ST_DRAIN  = 3'd5;
   localparam logic [2:0] ST_BLANK  = 3'd6;
   localparam logic [2:0] ST_FINISH = 3'd7;

   localparam int COL_W  = tcc_pkg::COL_W;
   localparam int ROW_W  = tcc_pkg::ROW_W;
   localparam int CNTC_W = tcc_pkg::CNTC_W;
   localparam int CNTR_W = tcc_pkg::CNTR_W;
   localparam int ADDR_W = tcc_pkg::ADDR_W;
   localparam int CHAR_W = tcc_pkg::CHAR_W;

   // Control registers.
   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [CNTC_W-1:0]  cols_ff, cols_in;
   logic [CNTR_W-1:0]  rows_ff, rows_in;
   logic [ROW_W-1:0]   cur_row_ff, cur_row_in;
   logic [COL_W-1:0]   cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]   sr_ff, sr_in;
   logic [COL_W-1:0]   sc_ff, sc_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Latched request word.
   logic                        rtype_ff, rtype_in;
   logic [CHAR_W-1:0]           rchar_ff, rchar_in;
   logic [tcc_pkg::FROW_W-1:0]  rrow_ff, rrow_in;
   logic [tcc_pkg::FCOL_W-1:0]  rcol_ff, rcol_in;

   // Result being assembled.
   logic                        res_wr_ff, res_wr_in;
   logic [ROW_W-1:0]            res_wrow_ff, res_wrow_in;
   logic [COL_W-1:0]            res_wcol_ff, res_wcol_in;
   logic [CHAR_W-1:0]           res_wchar_ff, res_wchar_in;
   logic                        res_scroll_ff, res_scroll_in;
   logic [CHAR_W-1:0]           res_rdata_ff, res_rdata_in;

   // Output word register.
   logic                        out_wr_ff, out_wr_in;
   logic [tcc_pkg::FROW_W-1:0]  out_wrow_ff, out_wrow_in;
   logic [tcc_pkg::FCOL_W-1:0]  out_wcol_ff, out_wcol_in;
   logic [CHAR_W-1:0]           out_wchar_ff, out_wchar_in;
   logic                        out_scroll_ff, out_scroll_in;
   logic [tcc_pkg::FROW_W-1:0]  out_crow_ff, out_crow_in;
   logic [tcc_pkg::FCOL_W-1:0]  out_ccol_ff, out_ccol_in;
   logic [CHAR_W-1:0]           out_rdata_ff, out_rdata_in;

   // Memory port signals.
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [CHAR_W-1:0]  mem_wr_data;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [CHAR_W-1:0]  mem_rd_data;

   // Helper values.
   logic [CNTC_W-1:0]  cols_m1;
   logic [CNTR_W-1:0]  rows_m1;
   logic [CNTC_W-1:0]  cols_in_m1;
   logic [CNTR_W-1:0]  rows_in_m1;
   logic [COL_W-1:0]   cc;
   logic [ROW_W-1:0]   cr;
   logic [CNTC_W-1:0]  ncol;
   logic [CNTR_W-1:0]  nrow;
   logic               put_wr;
   logic [COL_W-1:0]   put_col;
   logic [CHAR_W-1:0]  put_char;
   logic               put_scroll;
   logic               read_in_range;
   logic               last_col;
   logic               last_row;
   logic               req_fire;
   logic               out_free;

   tcc_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (tcc_pkg::STORE_DEPTH)
   ) u_cells (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_fire     = req_ch.valid && (state_ff == ST_IDLE);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // Effective limits minus one and the cursor clamped to the screen in use.
   assign cols_m1    = cols_ff - 1'b1;
   assign rows_m1    = rows_ff - 1'b1;
   assign cols_in_m1 = cols_in - 1'b1;
   assign rows_in_m1 = rows_in - 1'b1;
   assign cc = ({1'b0, cur_col_ff} >= cols_ff) ? cols_m1[COL_W-1:0] : cur_col_ff;
   assign cr = ({1'b0, cur_row_ff} >= rows_ff) ? rows_m1[ROW_W-1:0] : cur_row_ff;

   assign read_in_range = (32'(rrow_ff) < tcc_pkg::STORE_ROWS)
                       && (32'(rcol_ff) < tcc_pkg::STORE_COLS);

   // Scroll sweep position tests.
   assign last_col = ({1'b0, sc_ff} == cols_m1);
   assign last_row = ({1'b0, sr_ff} == rows_m1);

   // Cursor movement for a put word.
   always_comb begin
      ncol     = {1'b0, cc};
      nrow     = {1'b0, cr};
      put_wr   = 1'b0;
      put_col  = cc;
      put_char = rchar_ff;
      case (rchar_ff)
         tcc_pkg::CH_NEWLINE: begin
            ncol = '0;
            nrow = {1'b0, cr} + 1'b1;
         end
         tcc_pkg::CH_RETURN: begin
            ncol = '0;
         end
         tcc_pkg::CH_BACKSPACE: begin
            if (cc != '0) begin
               ncol     = {1'b0, cc} - 1'b1;
               put_wr   = 1'b1;
               put_col  = cc - 1'b1;
               put_char = tcc_pkg::CH_SPACE;
            end
         end
         default: begin
            put_wr = 1'b1;
            ncol   = {1'b0, cc} + 1'b1;
         end
      endcase
      if (ncol >= cols_ff) begin
         ncol = '0;
         nrow = nrow + 1'b1;
      end
      put_scroll = (nrow >= rows_ff);
      if (put_scroll) begin
         nrow = rows_m1;
      end
   end

   // Sequencer, memory port control and result assembly.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      sr_in         = sr_ff;
      sc_in         = sc_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      rtype_in      = rtype_ff;
      rchar_in      = rchar_ff;
      rrow_in       = rrow_ff;
      rcol_in       = rcol_ff;
      res_wr_in     = res_wr_ff;
      res_wrow_in   = res_wrow_ff;
      res_wcol_in   = res_wcol_ff;
      res_wchar_in  = res_wchar_ff;
      res_scroll_in = res_scroll_ff;
      res_rdata_in  = res_rdata_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = pend_addr_ff;
      mem_wr_data   = mem_rd_data;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = {sr_ff, sc_ff};
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      out_wr_in     = out_wr_ff;
      out_wrow_in   = out_wrow_ff;
      out_wcol_in   = out_wcol_ff;
      out_wchar_in  = out_wchar_ff;
      out_scroll_in = out_scroll_ff;
      out_crow_in   = out_crow_ff;
      out_ccol_in   = out_ccol_ff;
      out_rdata_in  = out_rdata_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(tcc_pkg::STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               rtype_in = req_ch.req_type;
               rchar_in = req_ch.char_code;
               rrow_in  = req_ch.read_row;
               rcol_in  = req_ch.read_col;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_rdata_in  = '0;
            res_scroll_in = 1'b0;
            res_wr_in     = 1'b0;
            res_wrow_in   = '0;
            res_wcol_in   = '0;
            res_wchar_in  = '0;
            if (rtype_ff == tcc_pkg::REQ_READ) begin
               cur_row_in  = cr;
               cur_col_in  = cc;
               mem_rd_en   = 1'b1;
               mem_rd_addr = {ROW_W'(rrow_ff), COL_W'(rcol_ff)};
               state_in    = ST_RDATA;
            end else begin
               // Store the character, move the cursor and start a scroll if needed.
               mem_wr_en     = put_wr;
               mem_wr_addr   = {cr, put_col};
               mem_wr_data   = put_char;
               res_wr_in     = put_wr;
               res_wrow_in   = put_wr ? cr : '0;
               res_wcol_in   = put_wr ? put_col : '0;
               res_wchar_in  = put_wr ? put_char : '0;
               res_scroll_in = put_scroll;
               cur_row_in    = nrow[ROW_W-1:0];
               cur_col_in    = ncol[COL_W-1:0];
               pend_in       = 1'b0;
               sc_in         = '0;
               sr_in         = ROW_W'(1);
               if (!put_scroll) begin
                  state_in = ST_FINISH;
               end else if (rows_ff == CNTR_W'(1)) begin
                  state_in = ST_BLANK;
               end else begin
                  state_in = ST_COPY;
               end
            end
         end
         ST_RDATA: begin
            res_rdata_in = read_in_range ? mem_rd_data : '0;
            state_in     = ST_FINISH;
         end
         ST_COPY: begin
            // Read a cell of the row below; write the previous read one row up.
            mem_rd_en    = 1'b1;
            mem_rd_addr  = {sr_ff, sc_ff};
            mem_wr_en    = pend_ff;
            pend_in      = 1'b1;
            pend_addr_in = {sr_ff - 1'b1, sc_ff};
            if (last_col) begin
               sc_in = '0;
               if (last_row) begin
                  state_in = ST_DRAIN;
               end else begin
                  sr_in = sr_ff + 1'b1;
               end
            end else begin
               sc_in = sc_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            mem_wr_en = pend_ff;
            pend_in   = 1'b0;
            sc_in     = '0;
            state_in  = ST_BLANK;
         end
         ST_BLANK: begin
            // Fill the bottom row in use with spaces.
            mem_wr_en   = 1'b1;
            mem_wr_addr = {rows_m1[ROW_W-1:0], sc_ff};
            mem_wr_data = tcc_pkg::CH_SPACE;
            if (last_col) begin
               state_in = ST_FINISH;
            end else begin
               sc_in = sc_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_wr_in     = res_wr_ff;
               out_wrow_in   = tcc_pkg::FROW_W'(res_wrow_ff);
               out_wcol_in   = tcc_pkg::FCOL_W'(res_wcol_ff);
               out_wchar_in  = res_wchar_ff;
               out_scroll_in = res_scroll_ff;
               out_crow_in   = tcc_pkg::FROW_W'(cur_row_ff);
               out_ccol_in   = tcc_pkg::FCOL_W'(cur_col_ff);
               out_rdata_in  = res_rdata_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Keep the cursor inside the screen in use, also when a register write shrinks it.
      if ({1'b0, cur_col_in} >= cols_in) begin
         cur_col_in = cols_in_m1[COL_W-1:0];
      end
      if ({1'b0, cur_row_in} >= rows_in) begin
         cur_row_in = rows_in_m1[ROW_W-1:0];
      end
   end

   // Configuration writes, clamped to between one and the store size.
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.reg_index)
            tcc_pkg::CSR_COLUMNS: begin
               if (csr_ch.wr_data == '0) begin
                  cols_in = CNTC_W'(1);
               end else if (32'(csr_ch.wr_data) > tcc_pkg::STORE_COLS) begin
                  cols_in = CNTC_W'(tcc_pkg::STORE_COLS);
               end else begin
                  cols_in = CNTC_W'(csr_ch.wr_data);
               end
            end
            tcc_pkg::CSR_ROWS: begin
               if (csr_ch.wr_data[6:0] == '0) begin
                  rows_in = CNTR_W'(1);
               end else if (32'(csr_ch.wr_data[6:0]) > tcc_pkg::STORE_ROWS) begin
                  rows_in = CNTR_W'(tcc_pkg::STORE_ROWS);
               end else begin
                  rows_in = CNTR_W'(csr_ch.wr_data[6:0]);
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cols_ff      <= CNTC_W'(tcc_pkg::STORE_COLS);
         rows_ff      <= CNTR_W'(tcc_pkg::STORE_ROWS);
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         cur_row_ff   <= cur_row_in;
         cur_col_ff   <= cur_col_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sr_ff         <= sr_in;
      sc_ff         <= sc_in;
      pend_addr_ff  <= pend_addr_in;
      rtype_ff      <= rtype_in;
      rchar_ff      <= rchar_in;
      rrow_ff       <= rrow_in;
      rcol_ff       <= rcol_in;
      res_wr_ff     <= res_wr_in;
      res_wrow_ff   <= res_wrow_in;
      res_wcol_ff   <= res_wcol_in;
      res_wchar_ff  <= res_wchar_in;
      res_scroll_ff <= res_scroll_in;
      res_rdata_ff  <= res_rdata_in;
      out_wr_ff     <= out_wr_in;
      out_wrow_ff   <= out_wrow_in;
      out_wcol_ff   <= out_wcol_in;
      out_wchar_ff  <= out_wchar_in;
      out_scroll_ff <= out_scroll_in;
      out_crow_ff   <= out_crow_in;
      out_ccol_ff   <= out_ccol_in;
      out_rdata_ff  <= out_rdata_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.cell_written   = out_wr_ff;
   assign rsp_ch.written_row    = out_wrow_ff;
   assign rsp_ch.written_col    = out_wcol_ff;
   assign rsp_ch.written_char   = out_wchar_ff;
   assign rsp_ch.did_scroll     = out_scroll_ff;
   assign rsp_ch.cursor_row_now = out_crow_ff;
   assign rsp_ch.cursor_col_now = out_ccol_ff;
   assign rsp_ch.read_char      = out_rdata_ff;

endmodule

// ===== sv/tcc_checker.sv =====
// Port-level checks for the console engine, bound to its top level.
module tcc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          cell_written,
   input logic [tcc_pkg::FROW_W-1:0]    written_row,
   input logic [tcc_pkg::FCOL_W-1:0]    written_col,
   input logic [tcc_pkg::CHAR_W-1:0]    written_char,
   input logic                          did_scroll,
   input logic [tcc_pkg::CHAR_W-1:0]    read_char
);

   // Reset leaves no word on the response side.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // One word is worked on at a time: no new word in the cycle after one is taken.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in progress");

   // Without a cell write the write fields read as zero.
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !cell_written) |->
         (written_row == '0 && written_col == '0 && written_char == '0))
      else $error("write fields set without a cell write");

   // A put word returns no read data.
   a_put_no_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (cell_written || did_scroll)) |-> (read_char == '0))
      else $error("read data on a put response");

   // A stalled response keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(written_char) && $stable(read_char)))
      else $error("stalled response changed");

endmodule

bind text_cell_console_engine tcc_checker u_tcc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .cell_written (rsp_ch.cell_written),
   .written_row  (rsp_ch.written_row),
   .written_col  (rsp_ch.written_col),
   .written_char (rsp_ch.written_char),
   .did_scroll   (rsp_ch.did_scroll),
   .read_char    (rsp_ch.read_char)
);

// ===== sim/text_cell_console_engine_test.sv =====
// Self-checking testbench for the text cell console engine: screen mirror plus random traffic.
module text_cell_console_engine_test;

   // Generous bound on the run.
   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int PHASES      = 12;

   typedef struct packed {
      logic                       kind;
      logic [tcc_pkg::CHAR_W-1:0] code;
      logic [tcc_pkg::FROW_W-1:0] row;
      logic [tcc_pkg::FCOL_W-1:0] col;
   } console_word_type;

   typedef struct packed {
      logic                       cell_written;
      logic [tcc_pkg::FROW_W-1:0] written_row;
      logic [tcc_pkg::FCOL_W-1:0] written_col;
      logic [tcc_pkg::CHAR_W-1:0] written_char;
      logic                       did_scroll;
      logic [tcc_pkg::FROW_W-1:0] cursor_row_now;
      logic [tcc_pkg::FCOL_W-1:0] cursor_col_now;
      logic [tcc_pkg::CHAR_W-1:0] read_char;
   } console_reply_type;

   // Mirror of the screen and cursor; it predicts the reply to every accepted word.
   class screen_mirror_type;
      logic [tcc_pkg::CHAR_W-1:0] screen [tcc_pkg::STORE_ROWS][tcc_pkg::STORE_COLS];
      int unsigned       width_reg, height_reg, cur_row, cur_col;
      console_reply_type awaited_replies [$];
      int unsigned       errors, puts, reads, scrolls, cell_writes, resizes;

      function new();
         foreach (screen[r, c]) screen[r][c] = '0;
         width_reg  = tcc_pkg::STORE_COLS;
         height_reg = tcc_pkg::STORE_ROWS;
         cur_row    = 0;
         cur_col    = 0;
      endfunction

      function int unsigned cols_used();
         if (width_reg < 1) return 1;
         if (width_reg > tcc_pkg::STORE_COLS) return tcc_pkg::STORE_COLS;
         return width_reg;
      endfunction

      function int unsigned rows_used();
         if (height_reg < 1) return 1;
         if (height_reg > tcc_pkg::STORE_ROWS) return tcc_pkg::STORE_ROWS;
         return height_reg;
      endfunction

      function void clamp_cursor();
         if (cur_col >= cols_used()) cur_col = cols_used() - 1;
         if (cur_row >= rows_used()) cur_row = rows_used() - 1;
      endfunction

      function void write_reg(logic [tcc_pkg::CSR_IDX_W-1:0] idx,
                              logic [tcc_pkg::CSR_DATA_W-1:0] value);
         if (idx == tcc_pkg::CSR_COLUMNS) begin
            width_reg = value;
         end else if (idx == tcc_pkg::CSR_ROWS) begin
            height_reg = value & 8'h7F;
         end
         clamp_cursor();
      endfunction

      // Only the columns in use move up; the bottom row of the area is blanked.
      function void scroll_up(int unsigned cols, int unsigned rows);
         for (int unsigned y = 0; y + 1 < rows; y++)
            for (int unsigned x = 0; x < cols; x++)
               screen[y][x] = screen[y + 1][x];
         for (int unsigned x = 0; x < cols; x++)
            screen[rows - 1][x] = tcc_pkg::CH_SPACE;
      endfunction

      function void note_request(console_word_type w);
         console_reply_type e;
         int unsigned       cols, rows;
         cols = cols_used();
         rows = rows_used();
         e    = '0;
         clamp_cursor();
         if (w.kind == tcc_pkg::REQ_READ) begin
            reads++;
            if (w.row < tcc_pkg::STORE_ROWS && w.col < tcc_pkg::STORE_COLS)
               e.read_char = screen[w.row][w.col];
         end else begin
            puts++;
            case (w.code)
               tcc_pkg::CH_NEWLINE: begin
                  cur_col = 0;
                  cur_row++;
               end
               tcc_pkg::CH_RETURN: begin
                  cur_col = 0;
               end
               tcc_pkg::CH_BACKSPACE: begin
                  // Backspace at the left edge leaves everything as it is.
                  if (cur_col != 0) begin
                     cur_col--;
                     screen[cur_row][cur_col] = tcc_pkg::CH_SPACE;
                     e.cell_written = 1'b1;
                     e.written_row  = tcc_pkg::FROW_W'(cur_row);
                     e.written_col  = tcc_pkg::FCOL_W'(cur_col);
                     e.written_char = tcc_pkg::CH_SPACE;
                  end
               end
               default: begin
                  screen[cur_row][cur_col] = w.code;
                  e.cell_written = 1'b1;
                  e.written_row  = tcc_pkg::FROW_W'(cur_row);
                  e.written_col  = tcc_pkg::FCOL_W'(cur_col);
                  e.written_char = w.code;
                  cur_col++;
               end
            endcase
            if (cur_col >= cols) begin
               cur_col = 0;
               cur_row++;
            end
            if (cur_row >= rows) begin
               scroll_up(cols, rows);
               cur_row     = rows - 1;
               e.did_scroll = 1'b1;
               scrolls++;
            end
            if (e.cell_written) cell_writes++;
         end
         e.cursor_row_now = tcc_pkg::FROW_W'(cur_row);
         e.cursor_col_now = tcc_pkg::FCOL_W'(cur_col);
         awaited_replies.push_back(e);
      endfunction

      function void check_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(console_reply_type got);
         console_reply_type e;
         if (awaited_replies.size() == 0) begin
            $display("%0t: reply word with none expected: expected nothing, actual %h",
                     $time, got);
            errors++;
            return;
         end
         e = awaited_replies.pop_front();
         check_field("cell_written",   e.cell_written,   got.cell_written);
         check_field("written_row",    e.written_row,    got.written_row);
         check_field("written_col",    e.written_col,    got.written_col);
         check_field("written_char",   e.written_char,   got.written_char);
         check_field("did_scroll",     e.did_scroll,     got.did_scroll);
         check_field("cursor_row_now", e.cursor_row_now, got.cursor_row_now);
         check_field("cursor_col_now", e.cursor_col_now, got.cursor_col_now);
         check_field("read_char",      e.read_char,      got.read_char);
      endfunction
   endclass

   logic clock;
   logic reset;
   int unsigned cycle_count;
   int unsigned req_gap_max;
   int unsigned rsp_gap_max;

   tcc_req_if req_ch();
   tcc_rsp_if rsp_ch();
   tcc_csr_if csr_ch();

   screen_mirror_type mirror = new();

   // Random phases: screen size, word count and share of newlines.
   int unsigned phase_cols  [PHASES] = '{6, 1, 16, 128, 3, 40, 2, 11, 129, 255, 0, 9};
   int unsigned phase_rows  [PHASES] = '{3, 5, 2, 2, 1, 3, 64, 6, 4, 127, 7, 65};
   int unsigned phase_words [PHASES] = '{130, 60, 100, 60, 60, 90, 80, 100, 40, 90, 60, 60};
   int unsigned phase_nl    [PHASES] = '{8, 8, 8, 8, 8, 8, 8, 8, 8, 60, 8, 8};

   text_cell_console_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Reply side: random stalls between words, checks every accepted word.
   initial begin
      console_reply_type got;
      int unsigned       stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = (rsp_gap_max == 0) ? 0 : $urandom_range(0, rsp_gap_max);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
         got.cell_written   = rsp_ch.cell_written;
         got.written_row    = rsp_ch.written_row;
         got.written_col    = rsp_ch.written_col;
         got.written_char   = rsp_ch.written_char;
         got.did_scroll     = rsp_ch.did_scroll;
         got.cursor_row_now = rsp_ch.cursor_row_now;
         got.cursor_col_now = rsp_ch.cursor_col_now;
         got.read_char      = rsp_ch.read_char;
         mirror.check_result(got);
      end
   end

   function automatic console_word_type put_word(logic [tcc_pkg::CHAR_W-1:0] code);
      console_word_type w;
      w.kind = tcc_pkg::REQ_PUT;
      w.code = code;
      w.row  = tcc_pkg::FROW_W'($urandom_range(0, 63));
      w.col  = tcc_pkg::FCOL_W'($urandom_range(0, 127));
      return w;
   endfunction

   function automatic console_word_type read_word(int unsigned row, int unsigned col);
      console_word_type w;
      w.kind = tcc_pkg::REQ_READ;
      w.code = tcc_pkg::CHAR_W'($urandom_range(0, 255));
      w.row  = tcc_pkg::FROW_W'(row);
      w.col  = tcc_pkg::FCOL_W'(col);
      return w;
   endfunction

   // Text-like traffic: printable bytes with line control, some reads and raw bytes.
   function automatic console_word_type text_word(int unsigned nl_pct);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         if ($urandom_range(0, 1) == 1)
            return read_word($urandom_range(0, mirror.rows_used() - 1),
                             $urandom_range(0, mirror.cols_used() - 1));
         return read_word($urandom_range(0, 63), $urandom_range(0, 127));
      end
      if (roll < 20 + nl_pct) return put_word(tcc_pkg::CH_NEWLINE);
      if (roll < 24 + nl_pct) return put_word(tcc_pkg::CH_RETURN);
      if (roll < 30 + nl_pct) return put_word(tcc_pkg::CH_BACKSPACE);
      if (roll < 85) return put_word(tcc_pkg::CHAR_W'($urandom_range(32, 126)));
      return put_word(tcc_pkg::CHAR_W'($urandom_range(0, 255)));
   endfunction

   task automatic send_word(console_word_type w);
      int unsigned gap;
      gap = (req_gap_max == 0) ? 0 : $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= w.kind;
      req_ch.char_code <= w.code;
      req_ch.read_row  <= w.row;
      req_ch.read_col  <= w.col;
      do @(posedge clock); while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
      mirror.note_request(w);
   endtask

   // Hold off until every reply is in, then let a full scroll of the current size finish.
   task automatic wait_until_idle();
      req_ch.valid <= 1'b0;
      while (mirror.awaited_replies.size() != 0) @(posedge clock);
      repeat (mirror.cols_used() * mirror.rows_used() + 16) @(posedge clock);
   endtask

   task automatic resize_screen(int unsigned cols, int unsigned rows);
      wait_until_idle();
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= tcc_pkg::CSR_COLUMNS;
      csr_ch.wr_data   <= tcc_pkg::CSR_DATA_W'(cols);
      do @(posedge clock); while (!(csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1));
      mirror.write_reg(tcc_pkg::CSR_COLUMNS, tcc_pkg::CSR_DATA_W'(cols));
      csr_ch.reg_index <= tcc_pkg::CSR_ROWS;
      csr_ch.wr_data   <= tcc_pkg::CSR_DATA_W'(rows);
      do @(posedge clock); while (!(csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1));
      mirror.write_reg(tcc_pkg::CSR_ROWS, tcc_pkg::CSR_DATA_W'(rows));
      csr_ch.valid <= 1'b0;
      mirror.resizes++;
   endtask

   task automatic run_directed();
      // Full screen after reset: empty cells, byte extremes, backspace mid-line and at the left edge.
      send_word(read_word(0, 0));
      send_word(read_word(63, 127));
      send_word(put_word(8'd65));
      send_word(put_word(8'd0));
      send_word(put_word(8'd255));
      send_word(put_word(8'd126));
      send_word(put_word(tcc_pkg::CH_BACKSPACE));
      send_word(put_word(tcc_pkg::CH_RETURN));
      send_word(put_word(tcc_pkg::CH_BACKSPACE));
      send_word(put_word(tcc_pkg::CH_NEWLINE));
      send_word(put_word(8'd104));
      send_word(put_word(8'd105));
      send_word(read_word(0, 2));
      // Shrink under the cursor, then wrap into a scroll; cells past the width stay.
      resize_screen(2, 1);
      send_word(put_word(8'd122));
      send_word(read_word(0, 0));
      send_word(read_word(0, 2));
      send_word(put_word(tcc_pkg::CH_NEWLINE));
      send_word(put_word(tcc_pkg::CH_BACKSPACE));
      send_word(put_word(tcc_pkg::CH_RETURN));
      // Zero sizes clamp to a single cell: a character or a newline put scrolls.
      resize_screen(0, 0);
      send_word(put_word(8'd113));
      send_word(put_word(tcc_pkg::CH_NEWLINE));
      send_word(read_word(0, 0));
      // Oversized values clamp to the full store.
      resize_screen(255, 127);
      send_word(put_word(8'd101));
      send_word(read_word(63, 0));
   endtask

   initial begin
      reset            <= 1'b1;
      cycle_count      <= 0;
      req_gap_max       = 17;
      rsp_gap_max       = 17;
      req_ch.valid     <= 1'b0;
      req_ch.req_type  <= tcc_pkg::REQ_PUT;
      req_ch.char_code <= '0;
      req_ch.read_row  <= '0;
      req_ch.read_col  <= '0;
      csr_ch.valid     <= 1'b0;
      csr_ch.reg_index <= tcc_pkg::CSR_COLUMNS;
      csr_ch.wr_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Random phases; some run with no idling on either side.
      for (int p = 0; p < PHASES; p++) begin
         resize_screen(phase_cols[p], phase_rows[p]);
         if (p % 4 == 2) begin
            req_gap_max = 0;
            rsp_gap_max = 0;
         end else begin
            req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
            rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
         end
         for (int n = 0; n < phase_words[p]; n++) send_word(text_word(phase_nl[p]));
      end

      wait_until_idle();
      $display("Run covered %0d puts and %0d reads over %0d screen sizes.",
               mirror.puts, mirror.reads, mirror.resizes + 1);
      $display("Cells written: %0d, scrolls: %0d.", mirror.cell_writes, mirror.scrolls);
      if (mirror.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/tcc_pkg.sv
sv/tcc_ifs.sv
sv/tcc_ram.sv
sv/text_cell_console_engine.sv
sv/tcc_checker.sv
sim/text_cell_console_engine_test.sv
